// File: hw/rtl/hsvc_pkg.sv
// Package for the HSV/RGB color converter: shared constants, types and helpers.
// Used by the front end, the queue, the back end and the top level.
package hsvc_pkg;

  localparam int unsigned FB = 16;
  localparam logic [16:0] ONE = 17'h10000;

  typedef enum logic {
    MODE_HSV2RGB = 1'b0,
    MODE_RGB2HSV = 1'b1
  } mode_e;

  // Conditioned item handed from the front end to the back end.
  typedef struct packed {
    mode_e       mode;
    logic [15:0] hue;
    logic [16:0] sat;
    logic [16:0] val;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } cond_t;

  localparam int unsigned CondW = $bits(cond_t);

  // Result of one conversion.
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] hue;
    logic [16:0] sat;
    logic [16:0] val;
  } res_t;

  localparam int unsigned ResW = $bits(res_t);

  // Reciprocal table indexed by an 8-bit divisor i: floor(2^k / (mul * i)), zero at i = 0.
  // It is built once at elaboration, so it ends up as plain lookup logic.
  typedef logic [255:0][24:0] recip_tab_t;

  function automatic recip_tab_t recip_tab(input int unsigned k, input int unsigned mul);
    recip_tab_t t;
    t = '0;
    for (int unsigned i = 1; i < 256; i++) begin
      t[i] = 25'((64'd1 << k) / 64'(mul * i));
    end
    return t;
  endfunction

  // Hue divides by six times the spread, saturation divides by the maximum.
  localparam recip_tab_t RecipHue = recip_tab(27, 6);
  localparam recip_tab_t RecipSat = recip_tab(24, 1);

endpackage

// File: hw/rtl/hsv_rgb_color_converter.sv
// HSV <-> RGB converter: one color per clock. A word accepted at a clock edge
// passes through the front register, the two-entry queue and the five-stage
// conversion pipe before its result is valid.
// Throughput is one item per cycle, limited only by the output handshake.
// Reset (rst_ni, asynchronous, low) clears all valid flags; data is unreset.
// Depends on hsvc_pkg, hsvc_front, hsvc_queue and hsvc_back.
module hsv_rgb_color_converter import hsvc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tuser: mode[0] (0 = HSV to RGB, 1 = RGB to HSV)
  input  logic         s_axis_tuser_i,
  // tdata: hue_in[23:0], saturation_in[47:24], value_in[71:48],
  //        red_in[87:72], green_in[103:88], blue_in[119:104]
  input  logic [119:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata: red_out[7:0], green_out[15:8], blue_out[23:16], hue_out[39:24],
  //        saturation_out[56:40], value_out[73:57], zero pad
  output logic [79:0]  m_axis_tdata_o
);

  // The front end conditions inputs; the queue decouples it from the
  // arithmetic pipe so either side can stall on its own.
  logic  f_valid, f_ready, q_valid, q_ready;
  cond_t f_item, q_item;
  res_t  res;

  hsvc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .mode_i  (s_axis_tuser_i),
    .hue_i   (s_axis_tdata_i[23:0]),
    .sat_i   (s_axis_tdata_i[47:24]),
    .val_i   (s_axis_tdata_i[71:48]),
    .red_i   (s_axis_tdata_i[87:72]),
    .green_i (s_axis_tdata_i[103:88]),
    .blue_i  (s_axis_tdata_i[119:104]),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .item_o  (f_item)
  );

  hsvc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .item_i  (f_item),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .item_o  (q_item)
  );

  hsvc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .ready_o (q_ready),
    .item_i  (q_item),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res)
  );

  assign m_axis_tdata_o = {6'd0, res.val, res.sat, res.hue, res.blue, res.green, res.red};

endmodule

// File: hw/rtl/hsvc_front.sv
// Front end: conditions one input item (hue fraction, clamps) into a register.
// Depends on hsvc_pkg.
module hsvc_front import hsvc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        mode_i,
  input  logic [23:0] hue_i,
  input  logic [23:0] sat_i,
  input  logic [23:0] val_i,
  input  logic [15:0] red_i,
  input  logic [15:0] green_i,
  input  logic [15:0] blue_i,
  output logic        valid_o,
  input  logic        ready_i,
  output cond_t       item_o
);

  logic  valid_q, valid_d;
  cond_t item_q, item_d;
  logic  [23:0] hue_abs;

  function automatic logic [16:0] clamp_q(input logic [23:0] x);
    logic [16:0] r;
    if (x[23]) r = '0;
    else if (x[22:0] > 23'(ONE)) r = ONE;
    else r = x[16:0];
    return r;
  endfunction

  function automatic logic [7:0] clamp_ch(input logic [15:0] x);
    logic [7:0] r;
    if (x[15]) r = '0;
    else if (x[14:8] != '0) r = 8'hFF;
    else r = x[7:0];
    return r;
  endfunction

  assign ready_o = !valid_q || ready_i;
  assign hue_abs = hue_i[23] ? (~hue_i + 24'd1) : hue_i;

  always_comb begin
    item_d = '0;
    item_d.mode = mode_e'(mode_i);
    if (mode_i == MODE_HSV2RGB) begin
      item_d.hue = hue_abs[15:0];
      item_d.sat = clamp_q(sat_i);
      item_d.val = clamp_q(val_i);
    end else begin
      item_d.red   = clamp_ch(red_i);
      item_d.green = clamp_ch(green_i);
      item_d.blue  = clamp_ch(blue_i);
    end
    valid_d = valid_q;
    if (ready_o) valid_d = valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hw/rtl/hsvc_queue.sv
// Two-entry queue between the front and the back end.
// Depends on hsvc_pkg.
module hsvc_queue import hsvc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  cond_t item_i,
  output logic  valid_o,
  input  logic  ready_i,
  output cond_t item_o
);

  cond_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= item_i;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !ready_o) else $error("full queue accepts");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("count slip");
`endif

endmodule

// File: hw/rtl/hsvc_back.sv
// Back end: pipelined conversion with reciprocal division, five stages.
// Depends on hsvc_pkg.
module hsvc_back import hsvc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  cond_t item_i,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  res_o
);

  localparam int unsigned NS = 5;

  logic [NS-1:0] vld_q;
  logic          adv;

  // The whole pipe advances together when the output stage is free.
  assign adv     = !vld_q[NS-1] || ready_i;
  assign ready_o = adv;
  assign valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  // ---------------- stage 1: sector, first products / mx, mn, numerator
  cond_t       c1_q;
  logic [2:0]  sec1_q;
  logic [15:0] f1_q;
  logic [32:0] fs1_q, gs1_q, p1_q;
  logic [7:0]  mx1_q, d1_q;
  logic [10:0] n1_q;

  logic [18:0] h6;
  logic [16:0] omf;
  logic [7:0]  mx, mn, dd;
  logic [10:0] nn;

  always_comb begin
    h6  = 19'(item_i.hue) * 19'd6;
    omf = ONE - 17'(h6[15:0]);
    mx = item_i.red;
    if (item_i.green > mx) mx = item_i.green;
    if (item_i.blue > mx) mx = item_i.blue;
    mn = item_i.red;
    if (item_i.green < mn) mn = item_i.green;
    if (item_i.blue < mn) mn = item_i.blue;
    dd = mx - mn;
    if (!(mx != item_i.red)) begin
      if (item_i.green >= item_i.blue) nn = 11'(item_i.green - item_i.blue);
      else nn = 11'(dd) * 11'd6 - 11'(item_i.blue - item_i.green);
    end else if (!(mx != item_i.green)) begin
      nn = 11'(dd) * 11'd2 + 11'(item_i.blue) - 11'(item_i.red);
    end else begin
      nn = 11'(dd) * 11'd4 + 11'(item_i.red) - 11'(item_i.green);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q   <= item_i;
      sec1_q <= h6[18:16];
      f1_q   <= h6[15:0];
      fs1_q  <= 33'(h6[15:0]) * 33'(item_i.sat);
      gs1_q  <= 33'(omf) * 33'(item_i.sat);
      p1_q   <= 33'(item_i.val) * 33'(ONE - item_i.sat);
      mx1_q  <= mx;
      d1_q   <= dd;
      n1_q   <= nn;
    end
  end

  // ---------------- stage 2: q, t products / reciprocal lookups
  // Value needs no divider: mx * 65536 / 255 is mx * 257 plus one when mx is
  // at least 128, which also reproduces the round-to-nearest.
  cond_t       c2_q;
  logic [2:0]  sec2_q;
  logic [16:0] p2_q;
  logic [33:0] q2_q, t2_q;
  logic [7:0]  mx2_q, d2_q;
  logic [26:0] nume2_q;
  logic [23:0] snum2_q;
  logic [10:0] div2_q;
  logic [24:0] rh2_q, rs2_q;
  logic [16:0] vq2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_q    <= c1_q;
      sec2_q  <= sec1_q;
      p2_q    <= p1_q[32:16];
      q2_q    <= 34'(c1_q.val) * 34'(ONE - fs1_q[32:16]);
      t2_q    <= 34'(c1_q.val) * 34'(ONE - gs1_q[32:16]);
      mx2_q   <= mx1_q;
      d2_q    <= d1_q;
      nume2_q <= {n1_q, 16'd0} + 27'(d1_q) * 27'd3;
      div2_q  <= 11'(d1_q) * 11'd6;
      snum2_q <= {d1_q, 16'd0} + 24'(mx1_q >> 1);
      rh2_q   <= RecipHue[d1_q];
      rs2_q   <= RecipSat[mx1_q];
      vq2_q   <= {1'b0, mx1_q, mx1_q} + 17'(mx1_q[7]);
    end
  end

  // ---------------- stage 3: channel rounding / reciprocal products
  // Each quotient estimate is either exact or one below the true quotient,
  // because both numerators stay below the table's power of two.
  cond_t       c3_q;
  logic [7:0]  r3_q, g3_q, b3_q;
  logic [16:0] hq3_q, sq3_q, vq3_q;
  logic [26:0] nume3_q;
  logic [23:0] snum3_q;
  logic [10:0] div3_q;
  logic [7:0]  mx3_q;
  logic        achr3_q, mx03_q;

  function automatic logic [7:0] to_ch(input logic [16:0] x);
    logic [25:0] m;
    m = 26'(x) * 26'd255 + 26'h8000;
    return m[23:16];
  endfunction

  logic [16:0] vv, tt, qq, rr, gg, bb;
  logic [51:0] hprod;
  logic [48:0] sprod;

  always_comb begin
    vv = c2_q.val;
    tt = t2_q[32:16];
    qq = q2_q[32:16];
    unique case (sec2_q)
      3'd0: begin rr = vv; gg = tt; bb = p2_q; end
      3'd1: begin rr = qq; gg = vv; bb = p2_q; end
      3'd2: begin rr = p2_q; gg = vv; bb = tt; end
      3'd3: begin rr = p2_q; gg = qq; bb = vv; end
      3'd4: begin rr = tt; gg = p2_q; bb = vv; end
      default: begin rr = vv; gg = p2_q; bb = qq; end
    endcase
    hprod = 52'(nume2_q) * 52'(rh2_q);
    sprod = 49'(snum2_q) * 49'(rs2_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c3_q    <= c2_q;
      r3_q    <= to_ch(rr);
      g3_q    <= to_ch(gg);
      b3_q    <= to_ch(bb);
      hq3_q   <= hprod[43:27];
      sq3_q   <= sprod[40:24];
      vq3_q   <= vq2_q;
      nume3_q <= nume2_q;
      snum3_q <= snum2_q;
      div3_q  <= div2_q;
      mx3_q   <= mx2_q;
      achr3_q <= d2_q == 8'd0;
      mx03_q  <= mx2_q == 8'd0;
    end
  end

  // ---------------- stage 4: quotient correction
  // A remainder that still holds the divisor means the estimate was one short.
  cond_t       c4_q;
  logic [7:0]  r4_q, g4_q, b4_q;
  logic [16:0] hq4_q, sq4_q, vq4_q;
  logic        achr4_q, mx04_q;

  logic [27:0] remh;
  logic [24:0] rems;

  always_comb begin
    remh = 28'(nume3_q) - 28'(hq3_q) * 28'(div3_q);
    rems = 25'(snum3_q) - 25'(sq3_q) * 25'(mx3_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c4_q    <= c3_q;
      r4_q    <= r3_q;
      g4_q    <= g3_q;
      b4_q    <= b3_q;
      hq4_q   <= hq3_q + 17'(remh >= 28'(div3_q));
      sq4_q   <= sq3_q + 17'(rems >= 25'(mx3_q));
      vq4_q   <= vq3_q;
      achr4_q <= achr3_q;
      mx04_q  <= mx03_q;
    end
  end

  // ---------------- stage 5: result select into the output register
  res_t res_d, res_q;

  always_comb begin
    res_d = '0;
    if (c4_q.mode == MODE_HSV2RGB) begin
      res_d.red = r4_q; res_d.green = g4_q; res_d.blue = b4_q;
      res_d.hue = c4_q.hue; res_d.sat = c4_q.sat; res_d.val = c4_q.val;
    end else begin
      res_d.red = c4_q.red; res_d.green = c4_q.green; res_d.blue = c4_q.blue;
      res_d.hue = achr4_q ? 16'd0 : hq4_q[15:0];
      res_d.sat = mx04_q ? 17'd0 : sq4_q;
      res_d.val = vq4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res_d;
  end

  assign res_o = res_q;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> valid_o) else $error("result dropped");
  a_val_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> res_o.val <= 17'(ONE)) else $error("value above one");
  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> res_o.sat <= 17'(ONE)) else $error("saturation above one");
`endif

endmodule
